[rtl/kdce_pkg.sv]
`timescale 1ns / 1ps
package kdce_pkg;

  localparam int MATRIX_ROWS = 4;
  localparam int MATRIX_COLS = 4;
  localparam int KEY_COUNT = MATRIX_ROWS * MATRIX_COLS;
  localparam int KEY_POS_W = $clog2(KEY_COUNT);
  localparam int KEY_IDX_W = $clog2(KEY_COUNT + 1);
  localparam int CODE_W = 14;
  localparam int TIME_W = 32;
  localparam int DEB_W = 8;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd30;
  // Largest code that still takes another digit
  localparam logic [CODE_W-1:0] CODE_APPEND_MAX = 14'd999;
  localparam logic [CODE_W-1:0] CODE_MAX = 14'd9999;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_CHANGED = 3'd1,
    EV_CANCEL  = 3'd2,
    EV_CONFIRM = 3'd3,
    EV_STATUS  = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    KC_DIGIT,
    KC_CLEAR,
    KC_CANCEL,
    KC_CONFIRM,
    KC_STATUS
  } key_class_t;

  // Newly stable press handed to the code entry logic
  typedef struct packed {
    logic                 press;
    logic [KEY_POS_W-1:0] pos;
  } key_press_t;

  // Layout, row by row: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
  function automatic key_class_t key_class(input logic [KEY_POS_W-1:0] pos);
    key_class_t c;
    case (pos)
      4'd3, 4'd14: c = KC_CONFIRM;  // A, hash
      4'd7, 4'd12: c = KC_CANCEL;   // B, star
      4'd11:       c = KC_CLEAR;    // C
      4'd15:       c = KC_STATUS;   // D
      default:     c = KC_DIGIT;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] key_digit(input logic [KEY_POS_W-1:0] pos);
    logic [3:0] d;
    case (pos)
      4'd0:    d = 4'd1;
      4'd1:    d = 4'd2;
      4'd2:    d = 4'd3;
      4'd4:    d = 4'd4;
      4'd5:    d = 4'd5;
      4'd6:    d = 4'd6;
      4'd8:    d = 4'd7;
      4'd9:    d = 4'd8;
      4'd10:   d = 4'd9;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

[rtl/kdce_code_entry.sv]
`timescale 1ns / 1ps
module kdce_code_entry (
  input  kdce_pkg::key_press_t              key,
  input  logic [kdce_pkg::CODE_W-1:0]       code,
  output logic [kdce_pkg::CODE_W-1:0]       code_next,
  output kdce_pkg::event_t                  ev
);

  kdce_pkg::key_class_t       cls;
  logic [3:0]                 digit;
  logic [kdce_pkg::CODE_W-1:0] appended;

  assign cls   = kdce_pkg::key_class(key.pos);
  assign digit = kdce_pkg::key_digit(key.pos);
  // code * 10 + digit; only used while code <= 999, so 14 bits hold it
  assign appended = (code << 3) + (code << 1) + {{(kdce_pkg::CODE_W-4){1'b0}}, digit};

  always_comb begin
    code_next = code;
    ev        = kdce_pkg::EV_NONE;
    if (key.press) begin
      case (cls)
        kdce_pkg::KC_DIGIT: begin
          if (code <= kdce_pkg::CODE_APPEND_MAX) begin
            code_next = appended;
          end
          ev = kdce_pkg::EV_CHANGED;
        end
        kdce_pkg::KC_CLEAR: begin
          code_next = '0;
          ev        = kdce_pkg::EV_CHANGED;
        end
        kdce_pkg::KC_CANCEL: begin
          code_next = '0;
          ev        = kdce_pkg::EV_CANCEL;
        end
        kdce_pkg::KC_CONFIRM: begin
          ev = (code != '0) ? kdce_pkg::EV_CONFIRM : kdce_pkg::EV_NONE;
        end
        default: begin
          ev = kdce_pkg::EV_STATUS;
        end
      endcase
    end
  end

endmodule

[rtl/keypad_debounce_code_entry.sv]
`timescale 1ns / 1ps
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: action; tdata: key_matrix, now_ms
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser: event_code;
//                                             tdata: selection_code, stable_key_index
// cfg       in   cfg_valid/cfg_ready          cfg_data: debounce_time_ms
//
// One word in, one word out. A word is held in the input register until the
// result register is free to take it; with no output stall, one word per cycle
// is sustained, set by the combinational debounce/code update.
// Reset (rst, sync, active high) clears key state, code, and sets debounce to 30 ms.
// A stalled output holds the result; the input register still drains into it
// the moment the consumer takes the old word, so no bubble is added.
module keypad_debounce_code_entry (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] key_matrix, [47:16] now_ms
  input  logic        s_axis_tuser,   // [0] action: 0 poll, 1 clear code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [13:0] selection_code, [18:14] stable_key_index,
                                      // [23:19] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] event_code
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data        // debounce_time_ms
);

  localparam int KC = kdce_pkg::KEY_COUNT;
  localparam int PW = kdce_pkg::KEY_POS_W;
  localparam int IW = kdce_pkg::KEY_IDX_W;
  localparam int CW = kdce_pkg::CODE_W;
  localparam int TW = kdce_pkg::TIME_W;
  localparam int DW = kdce_pkg::DEB_W;

  // Configuration
  logic [DW-1:0] hold_time_ms;

  // Input register
  logic          in_valid;
  logic          in_action;
  logic [KC-1:0] in_matrix;
  logic [TW-1:0] in_now;

  // Keypad state
  logic [IW-1:0] raw_key;
  logic [IW-1:0] stable_key;
  logic [TW-1:0] change_time;
  logic [CW-1:0] entered_code;

  // Result register
  logic             out_valid;
  kdce_pkg::event_t out_event;
  logic [CW-1:0]    out_code;
  logic [IW-1:0]    out_key;

  logic advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  // First pressed key in row-major order, 0 for none
  logic [IW-1:0] raw;
  always_comb begin
    raw = '0;
    for (int i = KC - 1; i >= 0; i--) begin
      if (in_matrix[i]) begin
        raw = IW'(i + 1);
      end
    end
  end

  logic          raw_changed;
  logic [TW-1:0] elapsed;
  logic          settled;
  logic          take_stable;

  assign raw_changed = raw != raw_key;
  // A changed raw key restarts the timer at now, so elapsed is zero
  assign elapsed     = raw_changed ? '0 : in_now - change_time;
  assign settled     = elapsed >= {{(TW-DW){1'b0}}, hold_time_ms};
  assign take_stable = !in_action && settled && (raw != stable_key);

  kdce_pkg::key_press_t press;
  logic [CW-1:0]        code_key;
  kdce_pkg::event_t     ev_key;

  assign press = '{press: take_stable && (raw != '0), pos: PW'(raw - IW'(1))};

  kdce_code_entry u_entry (
    .key       (press),
    .code      (entered_code),
    .code_next (code_key),
    .ev        (ev_key)
  );

  logic [CW-1:0]    entered_code_next;
  logic [IW-1:0]    stable_key_next;

  assign entered_code_next = in_action ? '0 : code_key;
  assign stable_key_next   = take_stable ? raw : stable_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time_ms <= kdce_pkg::DEBOUNCE_RESET;
      in_valid     <= 1'b0;
      out_valid    <= 1'b0;
      raw_key      <= '0;
      stable_key   <= '0;
      change_time  <= '0;
      entered_code <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        hold_time_ms <= cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        entered_code <= entered_code_next;
        stable_key   <= stable_key_next;
        if (!in_action && raw_changed) begin
          raw_key     <= raw;
          change_time <= in_now;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action <= s_axis_tuser;
      in_matrix <= s_axis_tdata[KC-1:0];
      in_now    <= s_axis_tdata[KC+TW-1:KC];
    end
    if (advance) begin
      out_event <= in_action ? kdce_pkg::EV_NONE : ev_key;
      out_code  <= entered_code_next;
      out_key   <= stable_key_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_event;
  assign m_axis_tdata  = {5'b0, out_key, out_code};

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    entered_code <= kdce_pkg::CODE_MAX)
    else $error("selection code above 9999");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    advance && in_action |=> out_code == '0 && out_event == kdce_pkg::EV_NONE)
    else $error("clear request did not zero the code");

  a_event_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_event != kdce_pkg::EV_NONE |-> out_key != '0)
    else $error("event without a stable key");

  a_stable_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(stable_key) && $stable(entered_code))
    else $error("keypad state moved without a word");

  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_code == entered_code && out_key == stable_key)
    else $error("result register out of step with state");

endmodule

[tb/tb_keypad_debounce_code_entry.sv]
`timescale 1ns / 1ps
module tb_keypad_debounce_code_entry;
  import kdce_pkg::*;

  localparam logic ACT_POLL = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;
  localparam int DRAIN_CYCLES = 4;     // covers the input and result registers plus margin
  localparam int STALL_LIMIT = 1000;   // cycles without any handshake
  localparam int RANDOM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 50;
  localparam int MAX_GAP = 18;

  // Face of each key, row-major, key 0 in the top byte
  localparam logic [8*KEY_COUNT-1:0] KEY_FACES = "123A456B789C*0#D";

  typedef struct packed {
    event_t            ev;
    logic [CODE_W-1:0] code;
    logic [4:0]        key;
  } keypad_word_t;

  typedef struct packed {
    logic         pinned;
    keypad_word_t word;
  } pin_note_t;

  typedef enum logic [1:0] {
    ROW_POLL,
    ROW_CLEAR,
    ROW_DEBOUNCE
  } row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    logic [15:0]  matrix;
    logic [31:0]  stamp;
    logic [7:0]   deb;
    logic         pinned;   // word below is the typed-in expectation
    keypad_word_t word;
  } dir_row_t;

  localparam int DIRECTED_ROWS = 29;
  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    // default 30 ms debounce
    '{ROW_POLL,     16'h0000, 32'd0,         8'd0,   1'b1, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h0001, 32'd100,       8'd0,   1'b1, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h0001, 32'd130,       8'd0,   1'b1, '{EV_CHANGED, 14'd1, 5'd1}},
    '{ROW_POLL,     16'h0000, 32'd140,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h0000, 32'd170,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    // all keys down: key 1 wins
    '{ROW_POLL,     16'hFFFF, 32'd200,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'hFFFF, 32'd230,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    // clear request ignores matrix and stamp, keeps the stable key
    '{ROW_CLEAR,    16'hFFFF, 32'hFFFF_FFFF, 8'd0,   1'b1, '{EV_NONE,    14'd0, 5'd1}},
    // zero debounce: a new raw key settles in the same poll
    '{ROW_DEBOUNCE, 16'h0000, 32'd0,         8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h8000, 32'd300,       8'd0,   1'b1, '{EV_STATUS,  14'd0, 5'd16}},
    '{ROW_POLL,     16'h0002, 32'd301,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h0004, 32'd302,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h0010, 32'd303,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h0020, 32'd304,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h4000, 32'd305,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h0800, 32'd306,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    // confirm on an empty code gives no event
    '{ROW_POLL,     16'h0008, 32'd307,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h2000, 32'd308,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h0200, 32'd309,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h0400, 32'd310,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h0200, 32'd311,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h0400, 32'd312,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    // code is full at four digits, 7 is dropped
    '{ROW_POLL,     16'h0100, 32'd313,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h1000, 32'd314,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h0080, 32'd315,       8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    // longest debounce, held across the timestamp wrap
    '{ROW_DEBOUNCE, 16'h0000, 32'd0,         8'd255, 1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h0001, 32'hFFFF_FF80, 8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h0001, 32'h0000_007E, 8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}},
    '{ROW_POLL,     16'h0001, 32'h0000_007F, 8'd0,   1'b0, '{EV_NONE,    14'd0, 5'd0}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;    // [15:0] key_matrix, [47:16] now_ms
  logic        s_axis_tuser = 1'b0;  // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [13:0] selection_code, [18:14] stable_key_index
  logic [2:0]  m_axis_tuser;         // [2:0] event_code
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  // keypad state as the block should hold it
  logic [DEB_W-1:0]  settle_ms = DEBOUNCE_RESET;
  logic [4:0]        raw_key_m = '0;
  logic [4:0]        stable_key_m = '0;
  logic [31:0]       raw_since_ms = '0;
  logic [CODE_W-1:0] code_m = '0;

  keypad_word_t due_words[$];
  pin_note_t    pinned_words[$];
  int           fail_count = 0;
  int           quiet_cycles = 0;
  int unsigned  fed_words = 0;
  logic         feed_steady = 1'b0;
  logic         drain_steady = 1'b0;

  always #4 clk = ~clk;

  keypad_debounce_code_entry u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // One poll or clear against the keypad state; returns the word it reports.
  function automatic keypad_word_t advance_keypad(input logic act, input logic [15:0] mat,
                                                  input logic [31:0] stamp);
    keypad_word_t w;
    logic [4:0]   hit;
    logic [7:0]   face;
    w.ev = EV_NONE;
    if (act == ACT_CLEAR) begin
      code_m = '0;
    end else begin
      hit = '0;
      for (int b = KEY_COUNT - 1; b >= 0; b--) begin
        if (mat[b]) hit = 5'(b + 1);
      end
      if (hit != raw_key_m) begin
        raw_key_m = hit;
        raw_since_ms = stamp;
      end
      if (32'(stamp - raw_since_ms) >= {24'd0, settle_ms} && hit != stable_key_m) begin
        stable_key_m = hit;
        if (hit != 0) begin
          face = KEY_FACES[8 * (KEY_COUNT - int'(hit)) +: 8];
          case (face)
            "A", "#": begin
              if (code_m != 0) w.ev = EV_CONFIRM;
            end
            "B", "*": begin
              code_m = '0;
              w.ev = EV_CANCEL;
            end
            "C": begin
              code_m = '0;
              w.ev = EV_CHANGED;
            end
            "D": begin
              w.ev = EV_STATUS;
            end
            default: begin
              if (code_m <= CODE_APPEND_MAX) code_m = code_m * 14'd10 + 14'(face - "0");
              w.ev = EV_CHANGED;
            end
          endcase
        end
      end
    end
    w.code = code_m;
    w.key = stable_key_m;
    return w;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic int unsigned draw_gap(input logic steady);
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Handshake monitor: predicts on every accepted input word, checks every output word.
  always @(posedge clk) begin : monitor
    keypad_word_t want;
    pin_note_t    note;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) settle_ms = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        want = advance_keypad(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16]);
        note = pinned_words.pop_front();
        due_words.push_back(note.pinned ? note.word : want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_words.size() == 0) begin
          $error("output word with none expected: tdata %h tuser %0d", m_axis_tdata,
                 m_axis_tuser);
          fail_count++;
        end else begin
          want = due_words.pop_front();
          check_field("event_code", want.ev, m_axis_tuser);
          check_field("selection_code", want.code, m_axis_tdata[13:0]);
          check_field("stable_key_index", want.key, m_axis_tdata[18:14]);
          check_field("tdata padding", 0, m_axis_tdata[23:19]);
        end
      end
      if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Output side: random stalls per word, with stretches of full throughput.
  initial begin : result_sink
    int unsigned gap;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 29) == 0) drain_steady = ~drain_steady;
      gap = draw_gap(drain_steady);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Valid stays up across back-to-back words; this task only drops it for a gap.
  task automatic send_word(input logic act, input logic [15:0] mat, input logic [31:0] stamp,
                           input logic pin = 1'b0, input keypad_word_t want = '0);
    int unsigned gap;
    pin_note_t   note;
    if ($urandom_range(0, 24) == 0) feed_steady = ~feed_steady;
    gap = draw_gap(feed_steady);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    note.pinned = pin;
    note.word = want;
    pinned_words.push_back(note);
    s_axis_tuser <= act;
    s_axis_tdata <= {stamp, mat};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    fed_words++;
  endtask

  // Stop feeding and wait until every predicted word is out and the pipe is empty.
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_debounce(input logic [7:0] ms);
    drain_block();
    cfg_data <= ms;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    dir_row_t    row;
    logic [7:0]  deb;
    logic [15:0] mat;
    int unsigned clock_ms;
    int unsigned t0;
    int unsigned phase_end;
    int          pos;
    int          pick;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      case (row.kind)
        ROW_DEBOUNCE: set_debounce(row.deb);
        ROW_CLEAR:    send_word(ACT_CLEAR, row.matrix, row.stamp, row.pinned, row.word);
        default:      send_word(ACT_POLL, row.matrix, row.stamp, row.pinned, row.word);
      endcase
    end

    clock_ms = 32'h0000_1000;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       deb = 8'd0;
        1:       deb = 8'd255;
        2:       deb = DEBOUNCE_RESET;
        default: deb = 8'($urandom_range(0, 255));
      endcase
      set_debounce(deb);
      phase_end = fed_words + WORDS_PER_PHASE;
      while (fed_words < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          // keystroke: optional bounce, hold past the debounce time, then release
          pos = $urandom_range(0, KEY_COUNT - 1);
          mat = 16'(1) << pos;
          if ($urandom_range(0, 3) == 0) mat = mat | (16'($urandom) << (pos + 1));
          if ($urandom_range(0, 4) == 0) begin
            clock_ms += $urandom_range(0, 3);
            send_word(ACT_POLL, 16'($urandom), clock_ms);
          end
          clock_ms += $urandom_range(0, 5);
          t0 = clock_ms;
          send_word(ACT_POLL, mat, t0);
          if ($urandom_range(0, 2) == 0) send_word(ACT_POLL, mat, t0 + $urandom_range(0, deb));
          // now and then the hold is cut short
          if ($urandom_range(0, 5) == 0) clock_ms = t0 + $urandom_range(0, deb);
          else clock_ms = t0 + deb + $urandom_range(0, 2);
          send_word(ACT_POLL, mat, clock_ms);
          clock_ms += $urandom_range(1, 5);
          send_word(ACT_POLL, 16'h0000, clock_ms);
          if ($urandom_range(0, 3) != 0) begin
            clock_ms += deb + $urandom_range(0, 2);
            send_word(ACT_POLL, 16'h0000, clock_ms);
          end
        end else if (pick == 6) begin
          send_word(ACT_CLEAR, 16'($urandom), $urandom);
        end else if (pick < 9) begin
          clock_ms += $urandom_range(0, 300);
          send_word(ACT_POLL, 16'($urandom), clock_ms);
        end else begin
          // arbitrary jump, wraps the timestamp now and then
          clock_ms += $urandom;
          send_word(ACT_POLL, 16'($urandom), clock_ms);
        end
      end
    end

    drain_block();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
